### hdl/rfd_pkg.sv
// rfd_pkg: types, command codes and constants shared by the frame decoder.
// No dependencies; imported by rfd_decode and rts_frame_decoder_unit.
package rfd_pkg;

  // protocol variants
  typedef enum logic [1:0] {
    PROTO_RTS = 2'd0,
    PROTO_RTW = 2'd1,
    PROTO_RTV = 2'd2
  } rfd_proto_e;

  // command codes
  localparam logic [7:0] CMD_MY       = 8'h01;
  localparam logic [7:0] CMD_BTN_MAX  = 8'h0A;
  localparam logic [7:0] CMD_STEPDOWN = 8'h0B;
  localparam logic [7:0] CMD_TOGGLE   = 8'h0C;
  localparam logic [7:0] CMD_SENSOR   = 8'h0E;
  localparam logic [3:0] CMD_VARIANT  = 4'hF;
  localparam logic [7:0] CMD_STEPUP   = 8'h8B;
  localparam logic [7:0] CMD_FAVORITE = 8'hC1;
  localparam logic [7:0] CMD_STOP     = 8'hF1;

  // key byte thresholds for the key-coded variants
  localparam logic [7:0] KEY_RTS_MIN  = 8'd160;
  localparam logic [7:0] KEY_TOGGLE   = 8'd164;
  localparam logic [7:0] KEY_RTV_BASE = 8'd148;
  localparam logic [7:0] KEY_RTW_BASE = 8'd132;

  localparam logic [23:0] ADDR_ALL_ONES = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [7:0] b9;
    logic       long_frame;
  } rfd_frame_t;

  typedef struct packed {
    logic        frame_valid;
    logic [7:0]  command_code;
    logic [1:0]  protocol_kind;
    logic [7:0]  key_value;
    logic [15:0] rolling_code;
    logic [23:0] remote_address;
    logic [3:0]  received_checksum;
    logic [6:0]  step_size;
  } rfd_result_t;

endpackage

### hdl/rfd_decode.sv
// rfd_decode: single-pass combinational decode of one registered frame.
// Depends on rfd_pkg for the frame and result structs and command codes.
module rfd_decode (
  input  rfd_pkg::rfd_frame_t  frame_i,
  output rfd_pkg::rfd_result_t result_o
);
  import rfd_pkg::*;

  logic [7:0]  dec1, dec2, dec3, dec4, dec5, dec6;
  logic [7:0]  key;
  logic [3:0]  nib_cmd;
  logic [3:0]  sum;
  logic [3:0]  rxsum;
  logic [3:0]  parity;
  logic [7:0]  cmd_base;
  logic [7:0]  cmd_final;
  rfd_proto_e  proto;
  logic [15:0] roll;
  logic [23:0] addr;
  logic        base_ok;
  logic        ext_ok;
  logic        known;
  logic        cmd_ok;

  // de-obfuscation: each byte chained with the previous raw byte
  assign key  = frame_i.b0;
  assign dec1 = frame_i.b1 ^ frame_i.b0;
  assign dec2 = frame_i.b2 ^ frame_i.b1;
  assign dec3 = frame_i.b3 ^ frame_i.b2;
  assign dec4 = frame_i.b4 ^ frame_i.b3;
  assign dec5 = frame_i.b5 ^ frame_i.b4;
  assign dec6 = frame_i.b6 ^ frame_i.b5;

  assign nib_cmd = dec1[7:4];
  assign rxsum   = dec1[3:0];
  assign roll    = {dec2, dec3};
  assign addr    = {dec4, dec5, dec6};

  // nibble XOR over decoded bytes 0..6, checksum nibble itself left out
  assign sum = key[7:4] ^ key[3:0] ^ nib_cmd
             ^ dec2[7:4] ^ dec2[3:0] ^ dec3[7:4] ^ dec3[3:0]
             ^ dec4[7:4] ^ dec4[3:0] ^ dec5[7:4] ^ dec5[3:0]
             ^ dec6[7:4] ^ dec6[3:0];

  assign parity = frame_i.b7[7:4] ^ frame_i.b8[7:4] ^ frame_i.b9[7:4]
                ^ frame_i.b7[3:0] ^ frame_i.b8[3:0];

  always_comb begin
    proto    = PROTO_RTS;
    cmd_base = {4'h0, nib_cmd};
    if (nib_cmd == CMD_VARIANT) begin
      priority if (key >= KEY_RTS_MIN) begin
        if (key == KEY_TOGGLE) cmd_base = CMD_TOGGLE;
      end else if (key > KEY_RTV_BASE) begin
        proto    = PROTO_RTV;
        cmd_base = key - KEY_RTV_BASE;
      end else if (key > KEY_RTW_BASE) begin
        proto    = PROTO_RTW;
        cmd_base = key - KEY_RTW_BASE;
      end else begin
        // low keys stay RTS with the bare variant nibble, which is not a known command
        proto    = PROTO_RTS;
      end
    end
  end

  assign base_ok = (rxsum == sum) && (addr != '0) && (addr != ADDR_ALL_ONES)
                 && ((cmd_base == CMD_SENSOR) || (roll != '0));

  // long-frame extension: only RTS frames that passed the base checks
  always_comb begin
    ext_ok    = base_ok;
    cmd_final = cmd_base;
    if (base_ok && (proto == PROTO_RTS) && frame_i.long_frame) begin
      ext_ok = (frame_i.b9[3:0] == parity);
      if (ext_ok) begin
        if (cmd_base == CMD_MY) begin
          cmd_final = {frame_i.b8[3:0], nib_cmd};
        end else if (cmd_base == CMD_STEPDOWN) begin
          cmd_final = {frame_i.b8[3], 3'b000, nib_cmd};
        end
      end
    end
  end

  assign known = ((cmd_final >= CMD_MY) && (cmd_final <= CMD_BTN_MAX))
               || (cmd_final == CMD_STEPDOWN) || (cmd_final == CMD_STEPUP)
               || (cmd_final == CMD_TOGGLE) || (cmd_final == CMD_SENSOR)
               || (cmd_final == CMD_FAVORITE) || (cmd_final == CMD_STOP);

  assign cmd_ok = ext_ok && known;

  always_comb begin
    result_o.frame_valid       = cmd_ok && (key != '0);
    result_o.command_code      = cmd_final;
    result_o.protocol_kind     = proto;
    result_o.key_value         = key;
    result_o.rolling_code      = roll;
    result_o.remote_address    = addr;
    result_o.received_checksum = rxsum;
    // step size survives a zero key
    if (cmd_ok && ((cmd_final == CMD_STEPDOWN) || (cmd_final == CMD_STEPUP))) begin
      result_o.step_size = {frame_i.b8[2:0], frame_i.b9[7:4]};
    end else begin
      result_o.step_size = '0;
    end
  end

endmodule

### hdl/rts_frame_decoder_unit.sv
// rts_frame_decoder_unit: top level of the radio frame decoder.
// Depends on rfd_pkg and rfd_decode.
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    byte_key_i .. byte_nine_i, long_frame_i
//  out      source     out_valid_o / out_ready_i  frame_valid_o .. step_size_o
//
// From input transfer to result: input register, decode, result register.
// One frame per cycle while out_ready_i is high; decode is XOR and compare logic only.
// Reset clears both valid flags; payload registers are not reset.
// A stall on the output holds the result register, then the input register,
// and only then drops in_ready_o.
module rts_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_key_i,
  input  logic [7:0]  byte_one_i,
  input  logic [7:0]  byte_two_i,
  input  logic [7:0]  byte_three_i,
  input  logic [7:0]  byte_four_i,
  input  logic [7:0]  byte_five_i,
  input  logic [7:0]  byte_six_i,
  input  logic [7:0]  byte_seven_i,
  input  logic [7:0]  byte_eight_i,
  input  logic [7:0]  byte_nine_i,
  input  logic        long_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_valid_o,
  output logic [7:0]  command_code_o,
  output logic [1:0]  protocol_kind_o,
  output logic [7:0]  key_value_o,
  output logic [15:0] rolling_code_o,
  output logic [23:0] remote_address_o,
  output logic [3:0]  received_checksum_o,
  output logic [6:0]  step_size_o
);
  import rfd_pkg::*;

  rfd_frame_t  frame_q, frame_d;
  rfd_result_t res_q, res_d;
  logic        s1_valid_q, s1_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        s1_ready;
  logic        in_xfer;
  logic        s1_xfer;

  assign s1_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_ready;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s1_xfer    = s1_valid_q && s1_ready;

  always_comb begin
    frame_d.b0         = byte_key_i;
    frame_d.b1         = byte_one_i;
    frame_d.b2         = byte_two_i;
    frame_d.b3         = byte_three_i;
    frame_d.b4         = byte_four_i;
    frame_d.b5         = byte_five_i;
    frame_d.b6         = byte_six_i;
    frame_d.b7         = byte_seven_i;
    frame_d.b8         = byte_eight_i;
    frame_d.b9         = byte_nine_i;
    frame_d.long_frame = long_frame_i;
  end

  rfd_decode u_decode (
    .frame_i  (frame_q),
    .result_o (res_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) frame_q <= frame_d;
    if (s1_xfer) res_q <= res_d;
  end

  assign out_valid_o         = out_valid_q;
  assign frame_valid_o       = res_q.frame_valid;
  assign command_code_o      = res_q.command_code;
  assign protocol_kind_o     = res_q.protocol_kind;
  assign key_value_o         = res_q.key_value;
  assign rolling_code_o      = res_q.rolling_code;
  assign remote_address_o    = res_q.remote_address;
  assign received_checksum_o = res_q.received_checksum;
  assign step_size_o         = res_q.step_size;

  a_in_xfer_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted frame not held in input register");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a full pipeline");

  a_valid_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_valid_o) |-> (key_value_o != '0))
    else $error("valid frame with zero key");

  a_step_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (step_size_o != '0)) |->
      ((command_code_o == CMD_STEPDOWN) || (command_code_o == CMD_STEPUP)))
    else $error("step size on a non-step command");

  a_variant_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (protocol_kind_o != PROTO_RTS)) |-> (command_code_o <= 8'd16))
    else $error("variant command out of range");

endmodule
